>>> hw/rtl/rtpj_pkg.sv
package rtpj_pkg;

  // header layout
  localparam int unsigned HEADER_BYTES = 20;
  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0] JPEG_TYPE_SPEC = 8'h00;

  // image size limits
  localparam int unsigned SIZE_W = 25;
  localparam logic [SIZE_W-1:0] MAX_IMAGE_BYTES = 25'h100_0000;

  // register indexes, word addressed (paddr[4:2])
  localparam logic [2:0] REG_MAX_PAYLOAD = 3'd0;
  localparam logic [2:0] REG_PAYLOAD_TYPE = 3'd1;
  localparam logic [2:0] REG_QUALITY = 3'd2;
  localparam logic [2:0] REG_FORMAT_CODE = 3'd3;
  localparam logic [2:0] REG_WIDTH_BLOCKS = 3'd4;
  localparam logic [2:0] REG_HEIGHT_BLOCKS = 3'd5;
  localparam logic [2:0] REG_SSRC_WORD = 3'd6;

  // register reset values
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1400;
  localparam logic [6:0] PAYLOAD_TYPE_RST = 7'd26;
  localparam logic [7:0] QUALITY_RST = 8'd80;
  localparam logic [31:0] SSRC_RST = 32'h13F9_7E67;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
  } pend_t;

endpackage

>>> hw/rtl/rtp_jpeg_packetizer.sv
// RTP/JPEG packetizer: image bytes enter one per transaction, the first byte of
// an image carrying its size and 90 kHz timestamp, and leave as packets of at most
// the configured maximum of payload bytes (a maximum of zero counts as one), each
// led by a 12-byte RTP header and an 8-byte RFC 2435 JPEG header. A byte that
// opens a packet puts out the 20 header bytes and then the byte itself, one per
// cycle while out_stall is low, through the single output register, and the
// input channel stalls until the last header byte has been taken. Bytes outside
// an image and zero-size first bytes are absorbed with no output.
// too_large marks every byte of an image above 2^24 bytes. Sequence number, offset
// and marker are captured as each packet opens; the other header fields are read
// from the registers as the header goes out, so the user must write configuration
// through the APB port only while no packet is in flight; the block does not enforce this.
module rtp_jpeg_packetizer
  import rtpj_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              first_of_image,
  input  logic [SIZE_W-1:0] image_size,
  input  logic [31:0]       frame_timestamp,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              end_of_packet,
  output logic              too_large
);

  localparam logic [4:0] HDR_LAST = 5'(HEADER_BYTES);

  // configuration registers
  logic [15:0] max_payload;
  logic [6:0]  payload_type;
  logic [7:0]  quality;
  logic [7:0]  format_code;
  logic [7:0]  width_blocks;
  logic [7:0]  height_blocks;
  logic [31:0] ssrc_word;

  // packetizer state
  logic [15:0]       seq_counter;
  logic [23:0]       fragment_offset;
  logic [SIZE_W-1:0] image_bytes_left;
  logic [15:0]       packet_bytes_left;
  logic [31:0]       held_timestamp;
  logic              image_too_large;

  // header sequencer and snapshot
  logic        hdr_busy;
  logic [4:0]  hdr_idx;
  logic [15:0] seq_snap;
  logic [23:0] off_snap;
  logic        marker_snap;
  pend_t       pend;

  // combinational
  logic              in_accept;
  logic              out_free;
  logic              cfg_write;
  logic [SIZE_W-1:0] ibl_eff;
  logic [15:0]       pbl_eff;
  logic [23:0]       off_eff;
  logic [31:0]       ts_eff;
  logic              too_eff;
  logic [15:0]       ps_eff;
  logic              open_pkt;
  logic              marker;
  logic [15:0]       pbl_start;
  logic [15:0]       pbl_next;
  logic [7:0]        hdr_byte;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = hdr_busy || !out_free;
  assign in_accept = in_valid && !in_stall;

  // state as seen after a first byte restarts the image
  always_comb begin
    ibl_eff = first_of_image ? image_size : image_bytes_left;
    pbl_eff = first_of_image ? 16'd0 : packet_bytes_left;
    off_eff = first_of_image ? 24'd0 : fragment_offset;
    ts_eff = first_of_image ? frame_timestamp : held_timestamp;
    too_eff = first_of_image ? (image_size > MAX_IMAGE_BYTES) : image_too_large;
    ps_eff = (max_payload == 16'd0) ? 16'd1 : max_payload;
    open_pkt = (pbl_eff == 16'd0);
    marker = (ibl_eff <= {9'd0, ps_eff});
    pbl_start = open_pkt ? (marker ? ibl_eff[15:0] : ps_eff) : pbl_eff;
    pbl_next = pbl_start - 16'd1;
  end

  // header byte select, byte 0 goes out at packet open
  always_comb begin
    case (hdr_idx)
      5'd1:    hdr_byte = {marker_snap, payload_type};
      5'd2:    hdr_byte = seq_snap[15:8];
      5'd3:    hdr_byte = seq_snap[7:0];
      5'd4:    hdr_byte = held_timestamp[31:24];
      5'd5:    hdr_byte = held_timestamp[23:16];
      5'd6:    hdr_byte = held_timestamp[15:8];
      5'd7:    hdr_byte = held_timestamp[7:0];
      5'd8:    hdr_byte = ssrc_word[31:24];
      5'd9:    hdr_byte = ssrc_word[23:16];
      5'd10:   hdr_byte = ssrc_word[15:8];
      5'd11:   hdr_byte = ssrc_word[7:0];
      5'd12:   hdr_byte = JPEG_TYPE_SPEC;
      5'd13:   hdr_byte = off_snap[23:16];
      5'd14:   hdr_byte = off_snap[15:8];
      5'd15:   hdr_byte = off_snap[7:0];
      5'd16:   hdr_byte = format_code;
      5'd17:   hdr_byte = quality;
      5'd18:   hdr_byte = width_blocks;
      5'd19:   hdr_byte = height_blocks;
      default: hdr_byte = RTP_VERSION_BYTE;
    endcase
  end

  // register read
  always_comb begin
    unique case (paddr[4:2])
      REG_MAX_PAYLOAD:   prdata = {16'd0, max_payload};
      REG_PAYLOAD_TYPE:  prdata = {25'd0, payload_type};
      REG_QUALITY:       prdata = {24'd0, quality};
      REG_FORMAT_CODE:   prdata = {24'd0, format_code};
      REG_WIDTH_BLOCKS:  prdata = {24'd0, width_blocks};
      REG_HEIGHT_BLOCKS: prdata = {24'd0, height_blocks};
      REG_SSRC_WORD:     prdata = ssrc_word;
      default:           prdata = 32'd0;
    endcase
  end

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RST;
      payload_type <= PAYLOAD_TYPE_RST;
      quality <= QUALITY_RST;
      format_code <= 8'd0;
      width_blocks <= 8'd0;
      height_blocks <= 8'd0;
      ssrc_word <= SSRC_RST;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_MAX_PAYLOAD:   max_payload <= pwdata[15:0];
        REG_PAYLOAD_TYPE:  payload_type <= pwdata[6:0];
        REG_QUALITY:       quality <= pwdata[7:0];
        REG_FORMAT_CODE:   format_code <= pwdata[7:0];
        REG_WIDTH_BLOCKS:  width_blocks <= pwdata[7:0];
        REG_HEIGHT_BLOCKS: height_blocks <= pwdata[7:0];
        REG_SSRC_WORD:     ssrc_word <= pwdata;
        default:           ;
      endcase
    end
  end

  // packet state, header sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_counter <= 16'd0;
      fragment_offset <= 24'd0;
      image_bytes_left <= '0;
      packet_bytes_left <= 16'd0;
      held_timestamp <= 32'd0;
      image_too_large <= 1'b0;
      hdr_busy <= 1'b0;
      hdr_idx <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      if (hdr_busy && out_free) begin
        // next header byte, then the held payload byte
        out_valid <= 1'b1;
        if (hdr_idx == HDR_LAST) begin
          out_byte <= pend.data;
          end_of_packet <= pend.eop;
          hdr_busy <= 1'b0;
        end else begin
          out_byte <= hdr_byte;
          end_of_packet <= 1'b0;
          hdr_idx <= hdr_idx + 5'd1;
        end
      end else if (in_accept) begin
        held_timestamp <= ts_eff;
        image_too_large <= too_eff;
        out_valid <= (ibl_eff != '0);
        if (ibl_eff != '0) begin
          image_bytes_left <= ibl_eff - SIZE_W'(1);
          packet_bytes_left <= pbl_next;
          fragment_offset <= off_eff + 24'd1;
          too_large <= too_eff;
          if (open_pkt) begin
            seq_counter <= seq_counter + 16'd1;
            seq_snap <= seq_counter;
            off_snap <= off_eff;
            marker_snap <= marker;
            pend.data <= data_byte;
            pend.eop <= (pbl_next == 16'd0);
            out_byte <= RTP_VERSION_BYTE;
            end_of_packet <= 1'b0;
            hdr_busy <= 1'b1;
            hdr_idx <= 5'd1;
          end else begin
            out_byte <= data_byte;
            end_of_packet <= (pbl_next == 16'd0);
          end
        end else begin
          image_bytes_left <= ibl_eff;
          packet_bytes_left <= pbl_eff;
          fragment_offset <= off_eff;
        end
      end else if (!out_stall) begin
        // output taken with nothing new to load
        out_valid <= 1'b0;
      end
    end
  end

  // checks
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    hdr_busy |-> (hdr_idx >= 5'd1 && hdr_idx <= HDR_LAST))
    else $error("header index out of range");

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    hdr_busy |-> (out_valid && !end_of_packet))
    else $error("header in flight without a header byte in the output register");

  a_hdr_done: assert property (@(posedge clk) disable iff (rst)
    (hdr_busy && out_free && hdr_idx == HDR_LAST) |=> (!hdr_busy && out_valid))
    else $error("payload byte not released after the last header byte");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    $rose(hdr_busy) |-> (seq_counter == seq_snap + 16'd1))
    else $error("sequence number did not advance at packet open");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rtpj_pkg::*;

  // one byte leaving the packetizer
  typedef struct packed {
    logic [7:0] value;
    logic       eop;
    logic       oversize;
  } packet_byte_t;

  // receiver stall patterns
  typedef enum int unsigned {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  // predicts packet bytes from image bytes and checks what comes out
  class packet_scoreboard;
    // register copy
    logic [15:0]       pkt_limit;
    logic [6:0]        pt_code;
    logic [7:0]        q_byte;
    logic [7:0]        fmt_byte;
    logic [7:0]        width_div8;
    logic [7:0]        height_div8;
    logic [31:0]       ssrc_id;
    // packetizer state
    logic [15:0]       seq_num;
    logic [23:0]       frag_offset;
    logic [SIZE_W-1:0] image_left;
    logic [15:0]       packet_left;
    logic [31:0]       frame_ts;
    logic              oversize;
    packet_byte_t      expected_bytes[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      pkt_limit = MAX_PAYLOAD_RST;
      pt_code = PAYLOAD_TYPE_RST;
      q_byte = QUALITY_RST;
      fmt_byte = '0;
      width_div8 = '0;
      height_div8 = '0;
      ssrc_id = SSRC_RST;
      seq_num = '0;
      frag_offset = '0;
      image_left = '0;
      packet_left = '0;
      frame_ts = '0;
      oversize = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_MAX_PAYLOAD: pkt_limit = value[15:0];
        REG_PAYLOAD_TYPE: pt_code = value[6:0];
        REG_QUALITY: q_byte = value[7:0];
        REG_FORMAT_CODE: fmt_byte = value[7:0];
        REG_WIDTH_BLOCKS: width_div8 = value[7:0];
        REG_HEIGHT_BLOCKS: height_div8 = value[7:0];
        REG_SSRC_WORD: ssrc_id = value;
        default: ;
      endcase
    endfunction

    function void queue_byte(logic [7:0] value, logic eop);
      packet_byte_t item;
      item = {value, eop, oversize};
      expected_bytes.insert(expected_bytes.size(), item);
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    // note an accepted image byte
    function void note_image_byte(logic [7:0] data, logic first, logic [SIZE_W-1:0] size,
                                  logic [31:0] stamp);
      logic [15:0]  limit;
      logic         marker;
      logic [159:0] hdr;
      int           i;
      if (first) begin
        image_left = size;
        frag_offset = '0;
        packet_left = '0;
        frame_ts = stamp;
        oversize = size > MAX_IMAGE_BYTES;
      end
      if (image_left == 0) return;
      // open a packet: rtp header then jpeg header
      if (packet_left == 0) begin
        limit = (pkt_limit == 0) ? 16'd1 : pkt_limit;
        marker = image_left <= limit;
        hdr = {RTP_VERSION_BYTE, marker, pt_code, seq_num, frame_ts, ssrc_id,
               JPEG_TYPE_SPEC, frag_offset, fmt_byte, q_byte, width_div8, height_div8};
        for (i = HEADER_BYTES - 1; i >= 0; i--)
          queue_byte(hdr[i*8 +: 8], 1'b0);
        seq_num++;
        packet_left = marker ? image_left[15:0] : limit;
      end
      packet_left--;
      image_left--;
      frag_offset++;
      queue_byte(data, packet_left == 0);
    endfunction

    function void report_mismatch(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // compare one output transaction with the oldest prediction
    function void check_packet_byte(logic [7:0] value, logic eop, logic tl);
      packet_byte_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h eop %0b too_large %0b",
                                  value, eop, tl));
        return;
      end
      want = expected_bytes.pop_front();
      if (want.value !== value || want.eop !== eop || want.oversize !== tl)
        report_mismatch($sformatf("byte %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                  checked, want.value, want.eop, want.oversize,
                                  value, eop, tl));
      checked++;
    endfunction

    function void close();
      if (expected_bytes.size() != 0)
        report_mismatch($sformatf("%0d predicted bytes never arrived", expected_bytes.size()));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [4:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        data_byte;
  logic              first_of_image;
  logic [SIZE_W-1:0] image_size;
  logic [31:0]       frame_timestamp;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_byte;
  logic              end_of_packet;
  logic              too_large;

  packet_scoreboard sb;
  int unsigned      burst_left = 0;
  int unsigned      plan_left = 0;
  bit               hold_off_req = 1'b0;
  bit               hold_off_done = 1'b0;

  rtp_jpeg_packetizer u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .first_of_image(first_of_image),
    .image_size(image_size),
    .frame_timestamp(frame_timestamp),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .end_of_packet(end_of_packet),
    .too_large(too_large)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // check every output transaction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_packet_byte(out_byte, end_of_packet, too_large);
  end

  // receiver: changing stall patterns, one long hold-off
  initial begin : receiver
    int unsigned run;
    int unsigned n;
    rx_mode_t    mode;
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        run = $urandom_range(8, 60);
        mode = rx_mode_t'($urandom_range(0, 3));
        for (n = 0; n < run; n++) begin
          case (mode)
            RX_FREE: out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 20);
            RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 50);
            default: out_stall <= (n % 3 != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // run limit
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // offer one image byte in bursts, hold it until accepted
  task automatic offer(input logic [7:0] data, input logic first,
                       input logic [SIZE_W-1:0] size, input logic [31:0] stamp);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    data_byte <= data;
    first_of_image <= first;
    image_size <= size;
    frame_timestamp <= stamp;
    do @(posedge clk); while (in_stall);
    sb.note_image_byte(data, first, size, stamp);
  endtask

  task automatic send_image(input logic [SIZE_W-1:0] size, input int unsigned count);
    offer(8'($urandom), 1'b1, size, $urandom);
    repeat (count - 1) offer(8'($urandom), 1'b0, SIZE_W'($urandom), $urandom);
  endtask

  // stop offering, wait for all predicted bytes, then wait out a settling margin
  task automatic drain_block();
    int unsigned waited;
    in_valid <= 1'b0;
    burst_left = 0;
    waited = 0;
    while (sb.pending() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
  endtask

  // apb write: setup then access; back-to-back writes keep psel high
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
  endtask

  task automatic apb_idle();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] pick_max_payload();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(9, 64));
      3: return 16'($urandom);
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  // new settings between transactions, possibly mid-image
  task automatic reconfigure();
    drain_block();
    if ($urandom_range(0, 3) != 0) write_reg(REG_MAX_PAYLOAD, {16'd0, pick_max_payload()});
    if ($urandom_range(0, 1)) write_reg(REG_PAYLOAD_TYPE, $urandom_range(0, 127));
    if ($urandom_range(0, 1)) write_reg(REG_QUALITY, $urandom_range(0, 255));
    if ($urandom_range(0, 1)) write_reg(REG_FORMAT_CODE, $urandom_range(0, 255));
    if ($urandom_range(0, 1)) write_reg(REG_WIDTH_BLOCKS, $urandom_range(0, 254));
    if ($urandom_range(0, 1)) write_reg(REG_HEIGHT_BLOCKS, $urandom_range(0, 254));
    if ($urandom_range(0, 1)) write_reg(REG_SSRC_WORD, $urandom);
    apb_idle();
  endtask

  // next byte of a random image stream; stray bytes between images do not count
  task automatic send_stream_item(output bit counted);
    logic [SIZE_W-1:0] sz;
    int unsigned       sz_n;
    int unsigned       pick;
    counted = 1'b1;
    if (plan_left != 0) begin
      plan_left--;
      offer(8'($urandom), 1'b0, SIZE_W'($urandom), $urandom);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        counted = 1'b0;
        offer(8'($urandom), 1'b0, SIZE_W'($urandom), $urandom);
      end else begin
        if (pick < 12) sz = '0;
        else if (pick < 20) sz = SIZE_W'($urandom_range(32'h0100_0001, 32'h01FF_FFFF));
        else if (pick < 24) sz = MAX_IMAGE_BYTES;
        else if (pick < 40) sz = SIZE_W'($urandom_range(41, 160));
        else sz = SIZE_W'($urandom_range(1, 40));
        sz_n = 32'(sz);
        // huge images are cut short by the next first byte
        if (sz > 25'd200) plan_left = $urandom_range(0, 5);
        else if (sz_n != 0 && $urandom_range(0, 6) == 0) plan_left = $urandom_range(0, sz_n - 1);
        else if (sz_n != 0) plan_left = sz_n - 1;
        else plan_left = 0;
        offer(8'($urandom), 1'b1, sz, $urandom);
      end
    end
  endtask

  initial begin : main
    int unsigned random_items;
    bit          counted;
    sb = new();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    data_byte <= '0;
    first_of_image <= 1'b0;
    image_size <= '0;
    frame_timestamp <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: stray byte, zero size, small image, size extremes, abandoned images
    offer(8'hFF, 1'b0, '1, '1);
    offer(8'h00, 1'b1, '0, '1);
    offer(8'h00, 1'b1, 25'd3, 32'hFFFF_FFFF);
    offer(8'hFF, 1'b0, '0, '0);
    offer(8'hA5, 1'b0, 25'h0AA_AAAA, 32'h5555_5555);
    offer(8'h5A, 1'b1, '1, '0);
    offer(8'h3C, 1'b0, '1, '1);
    offer(8'hC3, 1'b1, MAX_IMAGE_BYTES, 32'h0123_4567);
    offer(8'h81, 1'b1, MAX_IMAGE_BYTES + 25'd1, 32'h89AB_CDEF);
    offer(8'h7E, 1'b0, '0, '0);
    offer(8'h18, 1'b1, '0, '0);

    // upper extremes, packet size zero
    drain_block();
    write_reg(REG_MAX_PAYLOAD, 32'd0);
    write_reg(REG_PAYLOAD_TYPE, 32'd127);
    write_reg(REG_QUALITY, 32'd255);
    write_reg(REG_FORMAT_CODE, 32'd255);
    write_reg(REG_WIDTH_BLOCKS, 32'd254);
    write_reg(REG_HEIGHT_BLOCKS, 32'd254);
    write_reg(REG_SSRC_WORD, 32'hFFFF_FFFF);
    apb_idle();
    send_image(25'd3, 3);

    // lower extremes
    drain_block();
    write_reg(REG_MAX_PAYLOAD, 32'd1);
    write_reg(REG_PAYLOAD_TYPE, 32'd0);
    write_reg(REG_QUALITY, 32'd0);
    write_reg(REG_FORMAT_CODE, 32'd0);
    write_reg(REG_WIDTH_BLOCKS, 32'd0);
    write_reg(REG_HEIGHT_BLOCKS, 32'd0);
    write_reg(REG_SSRC_WORD, 32'd0);
    apb_idle();
    send_image(25'd2, 2);

    // largest packet size
    drain_block();
    write_reg(REG_MAX_PAYLOAD, 32'd65535);
    apb_idle();
    send_image(25'd3, 3);

    // settings change in the middle of an image
    drain_block();
    write_reg(REG_MAX_PAYLOAD, 32'd2);
    apb_idle();
    send_image(25'd5, 2);
    drain_block();
    write_reg(REG_MAX_PAYLOAD, 32'd3);
    write_reg(REG_QUALITY, 32'd99);
    apb_idle();
    repeat (3) offer(8'($urandom), 1'b0, SIZE_W'($urandom), $urandom);

    // random image streams
    hold_off_req = 1'b1;
    random_items = 0;
    while (random_items < 360) begin
      if ($urandom_range(0, 7) == 0) reconfigure();
      repeat ($urandom_range(5, 40)) begin
        if (random_items < 360) begin
          send_stream_item(counted);
          if (counted) random_items++;
        end
      end
    end

    drain_block();
    sb.close();
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
